// ===== hw/rtl/ddste_pkg.sv =====
package ddste_pkg;

    localparam int SINE_ENTRIES    = 256;
    localparam int SAMPLE_RATE_HZ  = 50000;
    localparam int SINE_IDX_W      = $clog2(SINE_ENTRIES);

    localparam int PHASE_W         = 32;
    localparam int LEVEL_W         = 16;
    localparam int FACTOR_W        = 17;
    localparam int FRAC_BITS       = 15;
    localparam int SINE_W          = 27;
    localparam int AMP_SHIFT       = 30;
    localparam int SAMPLE_W        = SINE_W + 1 + LEVEL_W - AMP_SHIFT;
    localparam int DAC_W           = 16;
    localparam int DIGIT_W         = 4;
    localparam int PHASE_DIGITS    = PHASE_W / DIGIT_W;

    localparam int STEP_CNT_W      = $clog2(FACTOR_W);
    localparam int PHASE_CNT_W     = $clog2(PHASE_DIGITS);
    localparam int AMP_CNT_W       = $clog2(LEVEL_W);

    localparam int NOTES_PER_SCALE = 5;
    localparam int SCALES          = 3;
    localparam int STEP_ENTRIES    = NOTES_PER_SCALE * SCALES;
    localparam int STEP_IDX_W      = $clog2(STEP_ENTRIES);
    localparam int NOTE_W          = 3;
    localparam int SCALE_W         = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [DAC_W-1:0]   DAC_CMD_CHAN_B = 16'hB000;
    localparam logic [DAC_W-1:0]   DAC_MIDSCALE   = 16'd2048;
    localparam logic [LEVEL_W-1:0] ATTACK_RESET   = 16'd131;
    localparam logic [LEVEL_W-1:0] DECAY_RESET    = 16'd131;
    localparam logic [LEVEL_W-1:0] PEAK_RESET     = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK = 2'd0,
        REG_DECAY  = 2'd1,
        REG_PEAK   = 2'd2
    } cfg_reg_t;

    localparam logic [63:0] TWO_PI_Q61    = 64'hC90FDAA22168C234;
    localparam logic [63:0] PI_Q61        = 64'h6487ED5110B4611A;
    localparam logic [63:0] HALF_PI_Q61   = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q62       = 64'h4000000000000000;
    localparam logic [63:0] SINE_PEAK_Q15 = 64'd67076096;

    localparam logic [63:0] STEP_DIVISOR    = 64'd100 * 64'(SAMPLE_RATE_HZ);
    localparam logic [63:0] SINE_ANGLE_STEP = TWO_PI_Q61 / 64'(SINE_ENTRIES);
    localparam logic [63:0] SINE_ANGLE_REM  = TWO_PI_Q61 % 64'(SINE_ENTRIES);

    // (2k)(2k+1) for Taylor term k
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // phase step for a frequency given in hundredths of a hertz
    function automatic logic [PHASE_W-1:0] step_of(input logic [63:0] chz);
        return PHASE_W'((chz << 32) / STEP_DIVISOR);
    endfunction

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> sh);
    endfunction

    // quarter-wave Taylor series in Q62, evaluated at elaboration
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] ii;
        logic [63:0] x;
        logic [63:0] xq;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] mag;
        logic        neg;
        ii  = 64'(i);
        x   = SINE_ANGLE_STEP * ii + ((SINE_ANGLE_REM * ii) >> SINE_IDX_W);
        neg = 1'b0;
        if (x > PI_Q61)
        begin
            x   = TWO_PI_Q61 - x;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q61)
        begin
            x = (x > PI_Q61) ? 64'd0 : PI_Q61 - x;
        end
        xq = x << 1;
        x2 = mul_shift(xq, xq, 62);
        s  = ONE_Q62;
        for (int k = 12; k >= 1; k--)
        begin
            t = mul_shift(x2, s, 62) / TAYLOR_DIV[k];
            s = (t > ONE_Q62) ? 64'd0 : ONE_Q62 - t;
        end
        s   = mul_shift(xq, s, 62);
        mag = mul_shift(SINE_PEAK_Q15, s, 62);
        if (mag > SINE_PEAK_Q15)
        begin
            mag = SINE_PEAK_Q15;
        end
        return neg ? SINE_W'(64'd0 - mag) : SINE_W'(mag);
    endfunction

    typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_table_t;

    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_ROM = build_sine_table();

    localparam logic [PHASE_W-1:0] STEP_ROM [STEP_ENTRIES] = '{
        step_of(64'd22000), step_of(64'd24694), step_of(64'd29366), step_of(64'd32963),
        step_of(64'd37000),
        step_of(64'd26163), step_of(64'd29366), step_of(64'd32963), step_of(64'd39200),
        step_of(64'd44000),
        step_of(64'd19600), step_of(64'd22000), step_of(64'd24694), step_of(64'd29366),
        step_of(64'd32963)
    };

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = step_of(64'd40000);

endpackage

// ===== hw/rtl/dds_tone_with_envelope.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  note_held, note_select, scale_select, pitch_factor
// dac       output     dac_valid / dac_stall  dac_word
// cfg       input      cfg_we               cfg_index, cfg_data
//
// A held note runs the 17-step pitch multiplier, the 8-digit phase adder, the sine
// ROM register and the 16-step envelope multiplier; a released tick with a live
// envelope skips the pitch multiplier. A new item is taken only in idle.
// Reset: phase 0, step of a 400 Hz tone, envelope 0, registers at defaults.
// dac_stall holds the output register; a new item is taken while it waits, but the next result then waits in S_EMIT.
module dds_tone_with_envelope (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              note_held,
    input  logic [ddste_pkg::NOTE_W-1:0]      note_select,
    input  logic [ddste_pkg::SCALE_W-1:0]     scale_select,
    input  logic [ddste_pkg::FACTOR_W-1:0]    pitch_factor,
    output logic                              dac_valid,
    input  logic                              dac_stall,
    output logic [ddste_pkg::DAC_W-1:0]       dac_word,
    input  logic                              cfg_we,
    input  logic [ddste_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddste_pkg::LEVEL_W-1:0]     cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STEP  = 6'b000010,
        S_PHASE = 6'b000100,
        S_SINE  = 6'b001000,
        S_AMP   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [ddste_pkg::LEVEL_W-1:0]        attack_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        attack_next;
    logic [ddste_pkg::LEVEL_W-1:0]        decay_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        decay_next;
    logic [ddste_pkg::LEVEL_W-1:0]        peak_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        peak_next;
    logic [ddste_pkg::LEVEL_W-1:0]        env_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        env_next;
    logic [ddste_pkg::LEVEL_W-1:0]        amp_level_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        amp_level_next;
    logic                                 dac_valid_reg;
    logic                                 dac_valid_next;
    logic [ddste_pkg::DAC_W-1:0]          dac_word_reg;
    logic [ddste_pkg::DAC_W-1:0]          dac_word_next;
    logic [ddste_pkg::SINE_W-1:0]         sine_reg;

    logic                                 in_accept;
    logic                                 note_ok;
    logic [ddste_pkg::STEP_IDX_W-1:0]     rom_idx;
    logic [ddste_pkg::PHASE_W-1:0]        base_step;
    logic [ddste_pkg::LEVEL_W:0]          level_up;
    logic [ddste_pkg::LEVEL_W-1:0]        held_level;
    logic [ddste_pkg::LEVEL_W-1:0]        rel_level;
    logic                                 step_start;
    logic                                 step_done;
    logic [ddste_pkg::PHASE_W-1:0]        new_step;
    logic                                 phase_load;
    logic                                 phase_start;
    logic                                 phase_done;
    logic [ddste_pkg::SINE_IDX_W-1:0]     sine_idx;
    logic                                 amp_start;
    logic                                 amp_done;
    logic [ddste_pkg::SAMPLE_W-1:0]       sample;
    logic [ddste_pkg::DAC_W-1:0]          word;
    logic                                 out_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign dac_valid = dac_valid_reg;
    assign dac_word  = dac_word_reg;

    // an invalid note counts as a release
    assign note_ok = note_held
                  && (note_select < ddste_pkg::NOTE_W'(ddste_pkg::NOTES_PER_SCALE))
                  && (scale_select < ddste_pkg::SCALE_W'(ddste_pkg::SCALES));
    assign rom_idx = ddste_pkg::STEP_IDX_W'(scale_select)
                   * ddste_pkg::STEP_IDX_W'(ddste_pkg::NOTES_PER_SCALE)
                   + ddste_pkg::STEP_IDX_W'(note_select);
    assign base_step = note_ok ? ddste_pkg::STEP_ROM[rom_idx] : '0;

    assign level_up   = {1'b0, env_reg} + {1'b0, attack_reg};
    assign held_level = (env_reg < peak_reg)
                      ? ((level_up > {1'b0, peak_reg}) ? peak_reg
                                                       : level_up[ddste_pkg::LEVEL_W-1:0])
                      : env_reg;
    assign rel_level  = (env_reg > decay_reg) ? env_reg - decay_reg : '0;

    assign word = ({{(ddste_pkg::DAC_W - ddste_pkg::SAMPLE_W){sample[ddste_pkg::SAMPLE_W-1]}},
                    sample} + ddste_pkg::DAC_MIDSCALE) | ddste_pkg::DAC_CMD_CHAN_B;

    ddste_step_mul u_step_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (step_start),
        .base_step (base_step),
        .factor    (pitch_factor),
        .done      (step_done),
        .step      (new_step)
    );

    ddste_phase_acc u_phase_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_step (phase_load),
        .step_in   (new_step),
        .start     (phase_start),
        .done      (phase_done),
        .sine_idx  (sine_idx)
    );

    ddste_amp_mul u_amp_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (amp_start),
        .level  (amp_level_reg),
        .sine   (sine_reg),
        .done   (amp_done),
        .sample (sample)
    );

    always_comb
    begin
        attack_next = attack_reg;
        decay_next  = decay_reg;
        peak_next   = peak_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ddste_pkg::REG_ATTACK: attack_next = cfg_data;
                ddste_pkg::REG_DECAY:  decay_next  = cfg_data;
                ddste_pkg::REG_PEAK:   peak_next   = cfg_data;
                default:               attack_next = attack_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        env_next       = env_reg;
        amp_level_next = amp_level_reg;
        step_start     = 1'b0;
        phase_load     = 1'b0;
        phase_start    = 1'b0;
        amp_start      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (note_ok)
                    begin
                        // sample uses the level before this tick's attack
                        step_start     = 1'b1;
                        env_next       = held_level;
                        amp_level_next = env_reg;
                        state_next     = S_STEP;
                    end
                    else if (env_reg != '0)
                    begin
                        env_next       = rel_level;
                        amp_level_next = rel_level;
                        phase_start    = 1'b1;
                        state_next     = S_PHASE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STEP:
            begin
                if (step_done)
                begin
                    phase_load  = 1'b1;
                    phase_start = 1'b1;
                    state_next  = S_PHASE;
                end
            end
            S_PHASE:
            begin
                if (phase_done)
                begin
                    state_next = S_SINE;
                end
            end
            S_SINE:
            begin
                amp_start  = 1'b1;
                state_next = S_AMP;
            end
            S_AMP:
            begin
                if (amp_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!dac_valid_reg || !dac_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign dac_valid_next = out_load || (dac_valid_reg && dac_stall);
    assign dac_word_next  = out_load ? word : dac_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            attack_reg    <= ddste_pkg::ATTACK_RESET;
            decay_reg     <= ddste_pkg::DECAY_RESET;
            peak_reg      <= ddste_pkg::PEAK_RESET;
            env_reg       <= '0;
            dac_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            peak_reg      <= peak_next;
            env_reg       <= env_next;
            dac_valid_reg <= dac_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_level_reg <= amp_level_next;
        dac_word_reg  <= dac_word_next;
        sine_reg      <= ddste_pkg::SINE_ROM[sine_idx];
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_attack_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && note_ok |=> (env_reg <= $past(peak_reg)) || (env_reg == $past(env_reg)))
        else $error("attack pushed envelope above peak");

    a_decay_falls: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !note_ok && (env_reg != '0) |=> env_reg <= $past(env_reg))
        else $error("envelope rose on a release tick");

    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ($past(state_reg) == S_AMP) || ($past(state_reg) == S_EMIT))
        else $error("emit reached without envelope multiply");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dac_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("output valid raised outside emit");

endmodule

// ===== hw/rtl/ddste_step_mul.sv =====
module ddste_step_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ddste_pkg::PHASE_W-1:0]    base_step,
    input  logic [ddste_pkg::FACTOR_W-1:0]   factor,
    output logic                             done,
    output logic [ddste_pkg::PHASE_W-1:0]    step
);

    logic                                    busy_reg;
    logic                                    busy_next;
    logic                                    done_reg;
    logic                                    done_next;
    logic [ddste_pkg::STEP_CNT_W-1:0]        cnt_reg;
    logic [ddste_pkg::STEP_CNT_W-1:0]        cnt_next;
    logic [ddste_pkg::PHASE_W-1:0]           mcand_reg;
    logic [ddste_pkg::PHASE_W-1:0]           mcand_next;
    logic [ddste_pkg::FACTOR_W-1:0]          mplier_reg;
    logic [ddste_pkg::FACTOR_W-1:0]          mplier_next;
    logic [ddste_pkg::PHASE_W-1:0]           acc_reg;
    logic [ddste_pkg::PHASE_W-1:0]           acc_next;
    logic [ddste_pkg::FACTOR_W-1:0]          low_reg;
    logic [ddste_pkg::FACTOR_W-1:0]          low_next;
    logic [ddste_pkg::PHASE_W:0]             sum;
    logic [ddste_pkg::PHASE_W+ddste_pkg::FACTOR_W-1:0] product;

    // one multiplier bit per cycle, LSB first
    assign sum = {1'b0, acc_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
    assign product = {acc_reg, low_reg};
    assign step = product[ddste_pkg::FRAC_BITS +: ddste_pkg::PHASE_W];
    assign done = done_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        low_next    = low_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = base_step;
            mplier_next = factor;
            acc_next    = '0;
            low_next    = '0;
        end
        else if (busy_reg)
        begin
            acc_next    = sum[ddste_pkg::PHASE_W:1];
            low_next    = {sum[0], low_reg[ddste_pkg::FACTOR_W-1:1]};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == ddste_pkg::STEP_CNT_W'(ddste_pkg::FACTOR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        low_reg    <= low_next;
    end

endmodule

// ===== hw/rtl/ddste_phase_acc.sv =====
module ddste_phase_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_step,
    input  logic [ddste_pkg::PHASE_W-1:0]     step_in,
    input  logic                              start,
    output logic                              done,
    output logic [ddste_pkg::SINE_IDX_W-1:0]  sine_idx
);

    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic                                 carry_reg;
    logic                                 carry_next;
    logic [ddste_pkg::PHASE_CNT_W-1:0]    cnt_reg;
    logic [ddste_pkg::PHASE_CNT_W-1:0]    cnt_next;
    logic [ddste_pkg::PHASE_W-1:0]        phase_reg;
    logic [ddste_pkg::PHASE_W-1:0]        phase_next;
    logic [ddste_pkg::PHASE_W-1:0]        step_reg;
    logic [ddste_pkg::PHASE_W-1:0]        step_next;
    logic [ddste_pkg::DIGIT_W:0]          digit_sum;

    // both words rotate one digit per cycle; the step is back in place after a full turn
    assign digit_sum = {1'b0, phase_reg[ddste_pkg::DIGIT_W-1:0]}
                     + {1'b0, step_reg[ddste_pkg::DIGIT_W-1:0]}
                     + {{ddste_pkg::DIGIT_W{1'b0}}, carry_reg};
    assign sine_idx = phase_reg[ddste_pkg::PHASE_W-1 -: ddste_pkg::SINE_IDX_W];
    assign done = done_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        step_next  = load_step ? step_in : step_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            carry_next = 1'b0;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            phase_next = {digit_sum[ddste_pkg::DIGIT_W-1:0],
                          phase_reg[ddste_pkg::PHASE_W-1:ddste_pkg::DIGIT_W]};
            step_next  = {step_reg[ddste_pkg::DIGIT_W-1:0],
                          step_reg[ddste_pkg::PHASE_W-1:ddste_pkg::DIGIT_W]};
            carry_next = digit_sum[ddste_pkg::DIGIT_W];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == ddste_pkg::PHASE_CNT_W'(ddste_pkg::PHASE_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            carry_reg <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= '0;
            step_reg  <= ddste_pkg::PHASE_STEP_RESET;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hw/rtl/ddste_amp_mul.sv =====
module ddste_amp_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ddste_pkg::LEVEL_W-1:0]    level,
    input  logic [ddste_pkg::SINE_W-1:0]     sine,
    output logic                             done,
    output logic [ddste_pkg::SAMPLE_W-1:0]   sample
);

    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic [ddste_pkg::AMP_CNT_W-1:0]      cnt_reg;
    logic [ddste_pkg::AMP_CNT_W-1:0]      cnt_next;
    logic [ddste_pkg::SINE_W-1:0]         mcand_reg;
    logic [ddste_pkg::SINE_W-1:0]         mcand_next;
    logic [ddste_pkg::LEVEL_W-1:0]        mplier_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        mplier_next;
    logic [ddste_pkg::SINE_W:0]           acc_reg;
    logic [ddste_pkg::SINE_W:0]           acc_next;
    logic [ddste_pkg::LEVEL_W-1:0]        low_reg;
    logic [ddste_pkg::LEVEL_W-1:0]        low_next;
    logic [ddste_pkg::SINE_W:0]           sum;
    logic [ddste_pkg::SINE_W+ddste_pkg::LEVEL_W:0] product;

    // two's complement shift-add; an arithmetic shift of the product is a floor
    assign sum = acc_reg + (mplier_reg[0]
               ? {mcand_reg[ddste_pkg::SINE_W-1], mcand_reg} : '0);
    assign product = {acc_reg, low_reg};
    assign sample = product[ddste_pkg::AMP_SHIFT +: ddste_pkg::SAMPLE_W];
    assign done = done_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        low_next    = low_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = sine;
            mplier_next = level;
            acc_next    = '0;
            low_next    = '0;
        end
        else if (busy_reg)
        begin
            acc_next    = {sum[ddste_pkg::SINE_W], sum[ddste_pkg::SINE_W:1]};
            low_next    = {sum[0], low_reg[ddste_pkg::LEVEL_W-1:1]};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == ddste_pkg::AMP_CNT_W'(ddste_pkg::LEVEL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        low_reg    <= low_next;
    end

endmodule
